// ----- design/nmea_gga_sentence_parser_macros.svh -----
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser_macros
// assertion helpers for the parser top level rtl
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_SENTENCE_PARSER_MACROS_SVH
`define NMEA_GGA_SENTENCE_PARSER_MACROS_SVH

// same-cycle implication, gated by reset
`define NGGA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define NGGA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ngga_pkg.sv -----
// ----------------------------------------------------------------------------
// ngga_pkg
// shared types and constants of the gga sentence parser
// ----------------------------------------------------------------------------
`default_nettype none

package ngga_pkg;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_COLLECT,
        PH_DEAD
    } phase_t;

    typedef enum logic [1:0] {
        FS_START,
        FS_DIGITS,
        FS_ENDED
    } fstat_t;

    typedef struct packed {
        logic               time_present;
        logic [19:0]        time_value;
        logic signed [17:0] latitude;
        logic signed [17:0] longitude;
        logic [7:0]         fix_quality;
    } sent_rec_t;

    localparam logic [47:0] TAG_RESET = 48'h24474E474741;
    localparam logic        REG_TAG   = 1'b0;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int          HDR_LEN   = 6;
    localparam logic [3:0]  FLD_TIME  = 4'd1;
    localparam logic [3:0]  FLD_LAT   = 4'd2;
    localparam logic [3:0]  FLD_LON   = 4'd4;
    localparam logic [3:0]  FLD_FIX   = 4'd6;
    localparam logic [3:0]  FLD_MAX   = 4'd15;

    localparam logic [19:0] TIME_CAP  = 20'd999999;
    localparam logic [19:0] POS_CAP   = 20'd99999;
    localparam logic [19:0] FIX_CAP   = 20'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

`default_nettype wire

// ----- design/nmea_gga_sentence_parser.sv -----
// result path: the beat carrying the ending cr/lf or the byte that fills the line pushes
// its record into the queue on a header match, then the s1, s2, s3 and output time split registers
// throughput: one byte per cycle; input stalls only while the 4-entry record queue is full
// reset: asynchronous, clears framing state, queue and pipeline valids, no clearing pass
// header tag comes up as $GNGGA
// ----------------------------------------------------------------------------
// nmea_gga_sentence_parser
// gga sentence parser with apb configured header tag and stream ports
// ----------------------------------------------------------------------------
`default_nettype none
`include "nmea_gga_sentence_parser_macros.svh"

module nmea_gga_sentence_parser
    import ngga_pkg::*;
#(
    parameter int MAX_LINE = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // hour, minute, second, latitude, longitude,
                                             // fix_quality, zero fill
    output logic             m_axis_tuser,   // time_present
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic [47:0] tag_reg;
    logic        in_accept;
    logic        rec_push;
    sent_rec_t   front_rec;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    sent_rec_t   head_rec;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_TAG) ? {16'd0, tag_reg} : 64'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= TAG_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[3] == REG_TAG)
        begin
            tag_reg <= pwdata[47:0];
        end
    end

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    ngga_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (in_accept),
        .rx_byte    (s_axis_tdata),
        .header_tag (tag_reg),
        .rec_push   (rec_push),
        .rec        (front_rec)
    );

    ngga_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_push),
        .push_rec (front_rec),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_rec (head_rec)
    );

    ngga_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rec         (head_rec),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `NGGA_ASSERT_IMP(a_no_push_when_full, rec_push, !q_full, "record pushed into full queue")
    `NGGA_ASSERT_NXT(a_push_fills_queue, rec_push, !q_empty, "pushed record not held in queue")
    `NGGA_ASSERT_IMP(a_time_split_range, m_axis_tvalid,
                     m_axis_tdata[6:0] < 7'd100 && m_axis_tdata[13:7] < 7'd100
                     && m_axis_tdata[20:14] < 7'd100, "time split out of range")

endmodule

`default_nettype wire

// ----- design/ngga_front.sv -----
// ----------------------------------------------------------------------------
// ngga_front
// per-byte sentence framing, header check and field accumulation
// ----------------------------------------------------------------------------
`default_nettype none

module ngga_front
    import ngga_pkg::*;
#(
    parameter int MAX_LINE = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_accept,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [47:0] header_tag,
    output logic             rec_push,
    output sent_rec_t        rec
);

    localparam int CW = $clog2(MAX_LINE);
    localparam logic [CW-1:0] LIMIT = CW'(MAX_LINE - 1);
    localparam logic [CW-1:0] HDR_END = CW'(HDR_LEN);

    function automatic logic [7:0] hdr_char(input logic [47:0] tag, input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = tag[47:40];
            3'd1:    ch = tag[39:32];
            3'd2:    ch = tag[31:24];
            3'd3:    ch = tag[23:16];
            3'd4:    ch = tag[15:8];
            3'd5:    ch = tag[7:0];
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic [19:0] sat_digit(input logic [19:0] v, input logic [3:0] d,
                                              input logic [19:0] cap);
        logic [23:0] t;
        t = {4'd0, v} * 24'd10 + {20'd0, d};
        if (v >= cap)
        begin
            return cap;
        end
        if (t > {4'd0, cap})
        begin
            return cap;
        end
        return t[19:0];
    endfunction

    phase_t             phase_reg, phase_next;
    logic [CW-1:0]      cc_reg, cc_next;
    logic               hm_reg, hm_next;
    logic [3:0]         fn_reg, fn_next;
    fstat_t             fs_reg, fs_next;
    logic [19:0]        time_reg, time_next;
    logic               tseen_reg, tseen_next;
    logic signed [17:0] lat_reg, lat_next;
    logic signed [17:0] lon_reg, lon_next;
    logic               neg_reg, neg_next;
    logic [7:0]         fix_reg, fix_next;

    logic               fin;
    logic               close_now;
    logic               is_comma;
    logic [3:0]         digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cc_reg    <= '0;
            hm_reg    <= 1'b1;
            fn_reg    <= '0;
            fs_reg    <= FS_START;
            time_reg  <= '0;
            tseen_reg <= 1'b0;
            lat_reg   <= '0;
            lon_reg   <= '0;
            neg_reg   <= 1'b0;
            fix_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cc_reg    <= cc_next;
            hm_reg    <= hm_next;
            fn_reg    <= fn_next;
            fs_reg    <= fs_next;
            time_reg  <= time_next;
            tseen_reg <= tseen_next;
            lat_reg   <= lat_next;
            lon_reg   <= lon_next;
            neg_reg   <= neg_next;
            fix_reg   <= fix_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cc_next    = cc_reg;
        hm_next    = hm_reg;
        fn_next    = fn_reg;
        fs_next    = fs_reg;
        time_next  = time_reg;
        tseen_next = tseen_reg;
        lat_next   = lat_reg;
        lon_next   = lon_reg;
        neg_next   = neg_reg;
        fix_next   = fix_reg;
        rec_push   = 1'b0;
        fin        = 1'b0;
        close_now  = 1'b0;
        is_comma   = 1'b0;
        digit      = 4'(rx_byte - CH_ZERO);

        if (in_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == CH_DOLLAR)
                    begin
                        phase_next = PH_COLLECT;
                        cc_next    = CW'(1);
                        hm_next    = (header_tag[47:40] == CH_DOLLAR);
                        fn_next    = '0;
                        fs_next    = FS_START;
                        time_next  = '0;
                        tseen_next = 1'b0;
                        lat_next   = '0;
                        lon_next   = '0;
                        neg_next   = 1'b0;
                        fix_next   = '0;
                    end
                end
                PH_COLLECT, PH_DEAD:
                begin
                    if (rx_byte == CH_LF || rx_byte == CH_CR)
                    begin
                        fin       = 1'b1;
                        close_now = (phase_reg == PH_COLLECT);
                    end
                    else
                    begin
                        if (phase_reg == PH_COLLECT)
                        begin
                            if (cc_reg < HDR_END && hdr_char(header_tag, cc_reg[2:0]) != rx_byte)
                            begin
                                hm_next = 1'b0;
                            end
                            if (rx_byte == CH_NUL)
                            begin
                                close_now  = 1'b1;
                                phase_next = PH_DEAD;
                            end
                            else if (rx_byte == CH_COMMA)
                            begin
                                close_now = 1'b1;
                                is_comma  = 1'b1;
                            end
                            else
                            begin
                                // field character
                                if (fn_reg == FLD_TIME)
                                begin
                                    tseen_next = 1'b1;
                                end
                                if (fs_reg != FS_ENDED)
                                begin
                                    if (rx_byte inside {[CH_ZERO:CH_NINE]})
                                    begin
                                        fs_next = FS_DIGITS;
                                        case (fn_reg)
                                            FLD_TIME:
                                                time_next = sat_digit(time_reg, digit, TIME_CAP);
                                            FLD_LAT:
                                                lat_next = 18'(sat_digit({2'b00, lat_reg}, digit,
                                                                         POS_CAP));
                                            FLD_LON:
                                                lon_next = 18'(sat_digit({2'b00, lon_reg}, digit,
                                                                         POS_CAP));
                                            FLD_FIX:
                                                fix_next = 8'(sat_digit({12'd0, fix_reg}, digit,
                                                                        FIX_CAP));
                                            default:
                                                fs_next = FS_DIGITS;
                                        endcase
                                    end
                                    else if (rx_byte inside {CH_PLUS, CH_MINUS})
                                    begin
                                        if (fs_reg == FS_START)
                                        begin
                                            fs_next  = FS_DIGITS;
                                            neg_next = (rx_byte == CH_MINUS);
                                        end
                                        else
                                        begin
                                            fs_next = FS_ENDED;
                                        end
                                    end
                                    else if (rx_byte inside {CH_SPACE, CH_TAB, CH_VT, CH_FF})
                                    begin
                                        if (fs_reg != FS_START)
                                        begin
                                            fs_next = FS_ENDED;
                                        end
                                    end
                                    else
                                    begin
                                        fs_next = FS_ENDED;
                                    end
                                end
                            end
                        end
                        cc_next = cc_reg + 1'b1;
                        if (cc_next >= LIMIT)
                        begin
                            fin = 1'b1;
                            if (phase_next == PH_COLLECT)
                            begin
                                close_now = 1'b1;
                            end
                        end
                    end

                    // apply sign when a field closes: negate lat or lon, clear a negative time or fix
                    if (close_now && neg_next)
                    begin
                        case (fn_reg)
                            FLD_TIME: time_next = '0;
                            FLD_LAT:  lat_next  = -lat_next;
                            FLD_LON:  lon_next  = -lon_next;
                            FLD_FIX:  fix_next  = '0;
                            default:  fix_next  = fix_next;
                        endcase
                    end

                    if (is_comma)
                    begin
                        if (fn_reg != FLD_MAX)
                        begin
                            fn_next = fn_reg + 1'b1;
                        end
                        fs_next  = FS_START;
                        neg_next = 1'b0;
                    end

                    if (fin)
                    begin
                        if (phase_next == PH_COLLECT && cc_next < HDR_END
                            && hdr_char(header_tag, cc_next[2:0]) != CH_NUL)
                        begin
                            hm_next = 1'b0;
                        end
                        phase_next = PH_HUNT;
                        rec_push   = hm_next;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    assign rec.time_present = tseen_next;
    assign rec.time_value   = time_next;
    assign rec.latitude     = lat_next;
    assign rec.longitude    = lon_next;
    assign rec.fix_quality  = fix_next;

endmodule

`default_nettype wire

// ----- design/ngga_queue.sv -----
// ----------------------------------------------------------------------------
// ngga_queue
// short record queue between the byte parser and the result pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module ngga_queue
    import ngga_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire sent_rec_t push_rec,
    input  wire logic      pop,
    output logic           full,
    output logic           empty,
    output sent_rec_t      head_rec
);

    sent_rec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_rec = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/ngga_back.sv -----
// ----------------------------------------------------------------------------
// ngga_back
// splits the time value into hour, minute, second and holds the result beat
// ----------------------------------------------------------------------------
`default_nettype none

module ngga_back
    import ngga_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire sent_rec_t   q_rec,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // hour, minute, second, latitude, longitude,
                                            // fix_quality, zero fill
    output logic             m_axis_tuser   // time_present
);

    // floor(x / 10000) and floor(x / 100) from under-estimating reciprocals
    localparam logic [32:0] RECIP_10K = 33'd6710;
    localparam logic [23:0] RECIP_100 = 24'd655;

    logic        adv;

    logic        s1_valid_reg;
    sent_rec_t   s1_rec_reg;
    logic [32:0] s1_prod_reg;

    logic        s2_valid_reg;
    sent_rec_t   s2_rec_reg;
    logic [6:0]  s2_hour_reg;
    logic [13:0] s2_rem_reg;

    logic        s3_valid_reg;
    sent_rec_t   s3_rec_reg;
    logic [6:0]  s3_hour_reg;
    logic [13:0] s3_rem_reg;
    logic [23:0] s3_prod_reg;

    logic        out_valid_reg;
    sent_rec_t   out_rec_reg;
    logic [6:0]  out_hour_reg;
    logic [6:0]  out_min_reg;
    logic [6:0]  out_sec_reg;

    logic [6:0]  q0;
    logic [19:0] m0;
    logic [19:0] r0;
    logic [6:0]  hour_c;
    logic [13:0] rem_c;
    logic [6:0]  q1;
    logic [13:0] m1;
    logic [13:0] r1;
    logic [6:0]  min_c;
    logic [6:0]  sec_c;

    assign adv   = !out_valid_reg || m_axis_tready;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        q0 = s1_prod_reg[32:26];
        m0 = {13'd0, q0} * 20'd10000;
        r0 = s1_rec_reg.time_value - m0;
        if (r0 >= 20'd10000)
        begin
            hour_c = q0 + 1'b1;
            rem_c  = 14'(r0 - 20'd10000);
        end
        else
        begin
            hour_c = q0;
            rem_c  = r0[13:0];
        end

        q1 = s3_prod_reg[22:16];
        m1 = {7'd0, q1} * 14'd100;
        r1 = s3_rem_reg - m1;
        if (r1 >= 14'd100)
        begin
            min_c = q1 + 1'b1;
            sec_c = 7'(r1 - 14'd100);
        end
        else
        begin
            min_c = q1;
            sec_c = r1[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= !q_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_rec_reg   <= q_rec;
            s1_prod_reg  <= {13'd0, q_rec.time_value} * RECIP_10K;
            s2_rec_reg   <= s1_rec_reg;
            s2_hour_reg  <= hour_c;
            s2_rem_reg   <= rem_c;
            s3_rec_reg   <= s2_rec_reg;
            s3_hour_reg  <= s2_hour_reg;
            s3_rem_reg   <= s2_rem_reg;
            s3_prod_reg  <= {10'd0, s2_rem_reg} * RECIP_100;
            out_rec_reg  <= s3_rec_reg;
            out_hour_reg <= s3_hour_reg;
            out_min_reg  <= min_c;
            out_sec_reg  <= sec_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rec_reg.time_present;
    assign m_axis_tdata  = {7'd0, out_rec_reg.fix_quality, out_rec_reg.longitude,
                            out_rec_reg.latitude, out_sec_reg, out_min_reg, out_hour_reg};

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gga sentence parser: byte beats go in on the
// slave stream, a scoreboard predicts each sentence record and checks the
// master stream beats in order, the header tag is rewritten over apb between
// the random runs that follow the directed sentences
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import ngga_pkg::*;

    localparam int          LINE_LEN     = 128;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [3:0]  TAG_ADDR     = 4'(8 * REG_TAG);
    localparam logic [47:0] TAG_GPGGA    = 48'h244750474741;
    localparam logic [47:0] TAG_SHORT    = 48'h24474E000000;
    localparam logic [7:0]  CH_DOT       = 8'h2E;
    localparam logic [7:0]  BLANKS [4]   = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

    typedef struct {
        logic               time_present;
        logic [6:0]         hour, minute, second;
        logic signed [17:0] latitude, longitude;
        logic [7:0]         fix_quality;
    } gga_fix_t;

    class gga_scoreboard;
        logic [47:0] tag;
        phase_t      phase;
        int unsigned char_count;
        bit          hdr_ok;
        logic [3:0]  fld;
        fstat_t      fstat;
        int unsigned time_acc;
        bit          time_seen;
        int          lat_acc;
        int          lon_acc;
        bit          neg;
        int unsigned fix_acc;
        gga_fix_t    fix_q[$];
        int          errors;

        function new();
            tag = TAG_RESET;
            phase = PH_HUNT;
            errors = 0;
            clear_fields();
        endfunction

        function void set_tag(logic [47:0] value);
            tag = value;
        endfunction

        function logic [7:0] tag_char(int unsigned pos);
            return tag[47 - 8 * (pos % HDR_LEN) -: 8];
        endfunction

        function void clear_fields();
            char_count = 0;
            hdr_ok = 1'b1;
            fld = '0;
            fstat = FS_START;
            time_acc = 0;
            time_seen = 1'b0;
            lat_acc = 0;
            lon_acc = 0;
            neg = 1'b0;
            fix_acc = 0;
        endfunction

        function int unsigned sat_push(int unsigned v, int unsigned d, int unsigned cap);
            if (v >= cap)
                return cap;
            v = v * 10 + d;
            return (v > cap) ? cap : v;
        endfunction

        function void seal_field();
            if (!neg)
                return;
            case (fld)
                FLD_TIME: time_acc = 0;
                FLD_LAT:  lat_acc = -lat_acc;
                FLD_LON:  lon_acc = -lon_acc;
                FLD_FIX:  fix_acc = 0;
                default:  ;
            endcase
        endfunction

        function void take_char(logic [7:0] c);
            int unsigned d;
            if (fld == FLD_TIME)
                time_seen = 1'b1;
            if (fstat == FS_ENDED)
                return;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                d = c - CH_ZERO;
                fstat = FS_DIGITS;
                case (fld)
                    FLD_TIME: time_acc = sat_push(time_acc, d, TIME_CAP);
                    FLD_LAT:  lat_acc = sat_push(lat_acc, d, POS_CAP);
                    FLD_LON:  lon_acc = sat_push(lon_acc, d, POS_CAP);
                    FLD_FIX:  fix_acc = sat_push(fix_acc, d, FIX_CAP);
                    default:  ;
                endcase
            end
            else if (c == CH_PLUS || c == CH_MINUS)
            begin
                if (fstat == FS_START)
                begin
                    fstat = FS_DIGITS;
                    neg = (c == CH_MINUS);
                end
                else
                    fstat = FS_ENDED;
            end
            else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
            begin
                if (fstat != FS_START)
                    fstat = FS_ENDED;
            end
            else
                fstat = FS_ENDED;
        endfunction

        function void close_sentence();
            gga_fix_t r;
            if (phase == PH_COLLECT)
            begin
                seal_field();
                if (char_count < HDR_LEN && tag_char(char_count) != CH_NUL)
                    hdr_ok = 1'b0;
            end
            phase = PH_HUNT;
            if (!hdr_ok)
                return;
            r.time_present = time_seen;
            r.hour         = time_seen ? 7'(time_acc / 10000) : 7'd0;
            r.minute       = time_seen ? 7'((time_acc / 100) % 100) : 7'd0;
            r.second       = time_seen ? 7'(time_acc % 100) : 7'd0;
            r.latitude     = 18'(lat_acc);
            r.longitude    = 18'(lon_acc);
            r.fix_quality  = 8'(fix_acc);
            fix_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] c);
            if (phase == PH_HUNT)
            begin
                if (c == CH_DOLLAR)
                begin
                    clear_fields();
                    hdr_ok = (tag_char(0) == CH_DOLLAR);
                    char_count = 1;
                    phase = PH_COLLECT;
                end
            end
            else if (c == CH_LF || c == CH_CR)
                close_sentence();
            else
            begin
                if (phase == PH_COLLECT)
                begin
                    if (char_count < HDR_LEN && tag_char(char_count) != c)
                        hdr_ok = 1'b0;
                    if (c == CH_NUL)
                    begin
                        seal_field();
                        phase = PH_DEAD;
                    end
                    else if (c == CH_COMMA)
                    begin
                        seal_field();
                        if (fld < FLD_MAX)
                            fld++;
                        fstat = FS_START;
                        neg = 1'b0;
                    end
                    else
                        take_char(c);
                end
                char_count++;
                if (char_count >= LINE_LEN - 1)
                    close_sentence();
            end
        endfunction

        function void compare(string name, longint exp_val, longint act_val);
            if (exp_val != act_val)
            begin
                $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [71:0] d, logic u);
            gga_fix_t e;
            if (fix_q.size() == 0)
            begin
                $error("result beat with nothing expected: tdata %h tuser %b", d, u);
                errors++;
                return;
            end
            e = fix_q.pop_front();
            compare("time_present", e.time_present, u);
            compare("hour", e.hour, d[6:0]);
            compare("minute", e.minute, d[13:7]);
            compare("second", e.second, d[20:14]);
            compare("latitude", e.latitude, $signed(d[38:21]));
            compare("longitude", e.longitude, $signed(d[56:39]));
            compare("fix_quality", e.fix_quality, d[64:57]);
        endfunction

        function int pending();
            return fix_q.size();
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [63:0] pwdata        = '0;
    logic [63:0] prdata;
    logic        pready;

    gga_scoreboard sb;
    int            src_idle  = 16;
    int            sink_idle = 58;
    int            bytes_sent = 0;
    logic [7:0]    line_buf[$];

    nmea_gga_sentence_parser #(.MAX_LINE(LINE_LEN)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic add_field();
        int kind;
        int nd;
        kind = $urandom_range(99);
        if (kind < 12)
            return;
        if (kind < 18)
        begin
            line_buf.push_back(8'($urandom_range(32, 126)));
            return;
        end
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 2)) line_buf.push_back(BLANKS[$urandom_range(3)]);
        if ($urandom_range(99) < 25)
            line_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        nd = ($urandom_range(99) < 12) ? $urandom_range(7, 11) : $urandom_range(0, 6);
        repeat (nd) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
        case ($urandom_range(5))
            0:
            begin
                line_buf.push_back(CH_DOT);
                repeat ($urandom_range(1, 4)) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
            1: line_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            2:
            begin
                line_buf.push_back(BLANKS[$urandom_range(3)]);
                line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
            3: line_buf.push_back(8'($urandom_range(32, 126)));
            default: ;
        endcase
    endtask

    task automatic send_sentence();
        int         nf;
        int         ending;
        logic [7:0] ch;
        bit         cut;
        line_buf.delete();
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(255)));
        line_buf.push_back(CH_DOLLAR);
        cut = 1'b0;
        for (int i = 1; i < HDR_LEN && !cut; i++)
        begin
            ch = sb.tag_char(i);
            if (ch == CH_NUL && $urandom_range(1))
                cut = 1'b1;
            else
            begin
                if ($urandom_range(99) < 8)
                    ch = 8'($urandom_range(255));
                line_buf.push_back(ch);
            end
        end
        nf = ($urandom_range(99) < 10) ? $urandom_range(9, 18) : $urandom_range(0, 8);
        if (!(cut && $urandom_range(99) < 70))
        begin
            repeat (nf)
            begin
                line_buf.push_back(CH_COMMA);
                if ($urandom_range(99) < 3)
                    line_buf.push_back(CH_NUL);
                add_field();
            end
        end
        ending = $urandom_range(99);
        if (ending < 8)
        begin
            while (line_buf.size() < LINE_LEN + 4)
                line_buf.push_back(($urandom_range(99) < 80) ?
                                   8'(CH_ZERO + $urandom_range(9)) : CH_COMMA);
        end
        else if (ending >= 12)
        begin
            line_buf.push_back($urandom_range(1) ? CH_CR : CH_LF);
            if ($urandom_range(99) < 20)
                line_buf.push_back(CH_LF);
        end
        foreach (line_buf[k])
            send_byte(line_buf[k]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_sentences(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_sentence();
        send_byte(CH_CR);
        drain();
    endtask

    task automatic write_tag(input logic [47:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TAG_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_tag(value);
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // saturation, blank before sign, negative lat and fix
        send_text("$GNGGA,1234567, -4807x,,99999999,,-3");
        send_byte(CH_CR);
        // time absent, tab and plus sign
        send_text("$GNGGA,,");
        send_byte(CH_TAB);
        send_text("+12,");
        send_byte(CH_LF);
        // negative time, fix capped
        send_text("$GNGGA,-5,+99999,,-123456,,300");
        send_byte(CH_CR);
        // zero byte hides the rest
        send_text("$GNGGA,12");
        send_byte(CH_NUL);
        send_text(",34");
        send_byte(CH_CR);
        // short line and foreign header, no result
        send_text("$GNG");
        send_byte(CH_CR);
        send_text("$GPGGA,1");
        send_byte(CH_CR);
        send_byte(8'hFF);
        send_byte(CH_NUL);

        run_sentences(420);

        src_idle  = 58;
        sink_idle = 16;
        write_tag(TAG_GPGGA);
        run_sentences(450);

        src_idle  = 0;
        sink_idle = 0;
        write_tag('0);
        run_sentences(70);
        write_tag('1);
        run_sentences(70);
        write_tag(TAG_SHORT);
        run_sentences(150);
        write_tag(TAG_RESET);
        run_sentences(400);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
